@@ design/psg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants
// Register map constants and the control/timer structs passed between the
// sound generator blocks.
// ----------------------------------------------------------------------------
package psg_pkg;

   // Full-address registers
   localparam logic [15:0] ADDR_GLOBAL_CTRL = 16'h9003;
   localparam logic [15:0] ADDR_SAW_RATE    = 16'hB000;
   localparam logic [15:0] ADDR_SAW_PER_LO  = 16'hB001;
   localparam logic [15:0] ADDR_SAW_PER_HI  = 16'hB002;

   // Pulse channel page select (address bits 15..12) and register offsets
   localparam logic [3:0]  PAGE_PULSE_ONE   = 4'h9;
   localparam logic [3:0]  PAGE_PULSE_TWO   = 4'hA;
   localparam logic [11:0] OFS_PULSE_CTRL   = 12'h000;
   localparam logic [11:0] OFS_PULSE_PER_LO = 12'h001;
   localparam logic [11:0] OFS_PULSE_PER_HI = 12'h002;

   localparam int NUM_PULSE   = 2;
   localparam logic [3:0] SAW_PHASE_WRAP = 4'd14;

   typedef struct packed {
      logic [NUM_PULSE-1:0][3:0]  pulse_volume;
      logic [NUM_PULSE-1:0][2:0]  pulse_duty;
      logic [NUM_PULSE-1:0]       pulse_duty_bypass;
      logic [NUM_PULSE-1:0]       pulse_enable;
      logic [NUM_PULSE-1:0][11:0] pulse_period;
      logic [5:0]                 saw_rate;
      logic [11:0]                saw_period;
      logic                       saw_enable;
      logic                       halt_flag;
      logic                       shift_by_four;
      logic                       shift_by_eight;
   } ctrl_type;

   typedef struct packed {
      logic [NUM_PULSE-1:0][3:0] pulse_step;
      logic [7:0]                saw_accum;
   } phase_type;

endpackage

@@ design/psg_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_regfile: write-only channel registers
// Decodes bus writes by exact address match, with optional swap of
// address bits 0 and 1.
// ----------------------------------------------------------------------------
module psg_regfile (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [15:0]       wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              swap_addr_lines,
   output psg_pkg::ctrl_type ctrl
);
   import psg_pkg::*;

   ctrl_type    ctrl_ff;
   ctrl_type    ctrl_in;
   logic [15:0] addr_dec;
   logic        ch_hit;
   logic        ch_sel;

   assign addr_dec = swap_addr_lines ? {wr_addr[15:2], wr_addr[0], wr_addr[1]} : wr_addr;

   always_comb begin
      ctrl_in = ctrl_ff;
      ch_hit  = (addr_dec[15:12] == PAGE_PULSE_ONE) || (addr_dec[15:12] == PAGE_PULSE_TWO);
      ch_sel  = (addr_dec[15:12] == PAGE_PULSE_TWO);
      if (wr_en) begin
         if (addr_dec == ADDR_GLOBAL_CTRL) begin
            ctrl_in.halt_flag      = wr_data[0];
            ctrl_in.shift_by_four  = wr_data[1];
            ctrl_in.shift_by_eight = wr_data[2];
         end else if (addr_dec == ADDR_SAW_RATE) begin
            ctrl_in.saw_rate = wr_data[5:0];
         end else if (addr_dec == ADDR_SAW_PER_LO) begin
            ctrl_in.saw_period[7:0] = wr_data;
         end else if (addr_dec == ADDR_SAW_PER_HI) begin
            ctrl_in.saw_period[11:8] = wr_data[3:0];
            ctrl_in.saw_enable       = wr_data[7];
         end else if (ch_hit) begin
            case (addr_dec[11:0])
               OFS_PULSE_CTRL: begin
                  ctrl_in.pulse_volume[ch_sel]      = wr_data[3:0];
                  ctrl_in.pulse_duty[ch_sel]        = wr_data[6:4];
                  ctrl_in.pulse_duty_bypass[ch_sel] = wr_data[7];
               end
               OFS_PULSE_PER_LO: begin
                  ctrl_in.pulse_period[ch_sel][7:0] = wr_data;
               end
               OFS_PULSE_PER_HI: begin
                  ctrl_in.pulse_period[ch_sel][11:8] = wr_data[3:0];
                  ctrl_in.pulse_enable[ch_sel]       = wr_data[7];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

endmodule

@@ design/psg_timers.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_timers: period dividers and waveform sequencers
// Down-counters for the three channels, pulse duty steps and the saw
// phase/accumulator. Exposes the post-tick phase state for level output.
// ----------------------------------------------------------------------------
module psg_timers (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_en,
   input  psg_pkg::ctrl_type  ctrl,
   output psg_pkg::phase_type phase_next
);
   import psg_pkg::*;

   logic [NUM_PULSE-1:0][11:0] pulse_counter_ff, pulse_counter_in;
   logic [11:0]                saw_counter_ff, saw_counter_in;
   logic [3:0]                 saw_phase_ff, saw_phase_in;
   logic [3:0]                 saw_phase_inc;
   logic [7:0]                 saw_accum_add;
   phase_type                  phase_ff, phase_in;
   logic                       go;

   function automatic logic [11:0] reload_value(input logic [11:0] period,
                                                input logic s4, input logic s8);
      if (s8) begin
         return {8'd0, period[11:8]};
      end else if (s4) begin
         return {4'd0, period[11:4]};
      end
      return period;
   endfunction

   assign go = tick_en && !ctrl.halt_flag;

   always_comb begin
      pulse_counter_in = pulse_counter_ff;
      saw_counter_in   = saw_counter_ff;
      saw_phase_in     = saw_phase_ff;
      phase_in         = phase_ff;
      saw_phase_inc    = saw_phase_ff + 4'd1;
      saw_accum_add    = saw_phase_inc[0] ? phase_ff.saw_accum
                                          : phase_ff.saw_accum + {2'b00, ctrl.saw_rate};
      if (go) begin
         for (int ch = 0; ch < NUM_PULSE; ch++) begin
            if (pulse_counter_ff[ch] == 12'd0) begin
               pulse_counter_in[ch]    = reload_value(ctrl.pulse_period[ch],
                                                      ctrl.shift_by_four,
                                                      ctrl.shift_by_eight);
               phase_in.pulse_step[ch] = phase_ff.pulse_step[ch] + 4'd1;
            end else begin
               pulse_counter_in[ch] = pulse_counter_ff[ch] - 12'd1;
            end
         end
         if (saw_counter_ff == 12'd0) begin
            saw_counter_in = reload_value(ctrl.saw_period, ctrl.shift_by_four,
                                          ctrl.shift_by_eight);
            // wrap the 14-step sequence, clearing the accumulator
            if (saw_phase_inc >= SAW_PHASE_WRAP) begin
               saw_phase_in       = 4'd0;
               phase_in.saw_accum = 8'd0;
            end else begin
               saw_phase_in       = saw_phase_inc;
               phase_in.saw_accum = saw_accum_add;
            end
         end else begin
            saw_counter_in = saw_counter_ff - 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_counter_ff <= '0;
         saw_counter_ff   <= '0;
         saw_phase_ff     <= '0;
         phase_ff         <= '0;
      end else begin
         pulse_counter_ff <= pulse_counter_in;
         saw_counter_ff   <= saw_counter_in;
         saw_phase_ff     <= saw_phase_in;
         phase_ff         <= phase_in;
      end
   end

   assign phase_next = phase_in;

endmodule

@@ design/psg_levels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_levels: channel levels and mix
// Gates each channel by enable and duty, and forms 2*p1 + 2*p2 + saw.
// ----------------------------------------------------------------------------
module psg_levels (
   input  psg_pkg::ctrl_type  ctrl,
   input  psg_pkg::phase_type phase,
   output logic [3:0]         pulse_one_level,
   output logic [3:0]         pulse_two_level,
   output logic [4:0]         saw_level,
   output logic [6:0]         mix_level
);
   import psg_pkg::*;

   logic [NUM_PULSE-1:0][3:0] lvl;

   always_comb begin
      for (int ch = 0; ch < NUM_PULSE; ch++) begin
         if (!ctrl.pulse_enable[ch]) begin
            lvl[ch] = 4'd0;
         end else if (ctrl.pulse_duty_bypass[ch] ||
                      ((4'd15 - phase.pulse_step[ch]) <= {1'b0, ctrl.pulse_duty[ch]})) begin
            lvl[ch] = ctrl.pulse_volume[ch];
         end else begin
            lvl[ch] = 4'd0;
         end
      end
   end

   assign pulse_one_level = lvl[0];
   assign pulse_two_level = lvl[1];
   assign saw_level       = ctrl.saw_enable ? phase.saw_accum[7:3] : 5'd0;
   assign mix_level       = {2'b00, lvl[0], 1'b0} + {2'b00, lvl[1], 1'b0}
                          + {2'b00, saw_level};

endmodule

@@ design/pulse_saw_sound_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_saw_sound_generator: two pulse + one sawtooth sound generator
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+------------------------
//   req     | req_valid, req_stall, mode/addr/data   | one write or one tick
//   rsp     | rsp_valid, rsp_stall, four level ports | one sample set per tick
//   csr     | csr_valid, csr_ready, csr_data         | address-swap bit
//
// One transfer per cycle sustained while the result channel is not stalled.
// Each item is held in the input register, is processed on the way into
// the result register, and a tick's sample is presented from there.
// Writes update the register file and produce no result.
// A stalled result holds only ticks; writes keep draining behind it.
// Synchronous reset clears all channel state and the swap bit.
// ----------------------------------------------------------------------------
module pulse_saw_sound_generator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_pulse_one_level,
   output logic [3:0]  rsp_pulse_two_level,
   output logic [4:0]  rsp_saw_level,
   output logic [6:0]  rsp_mix_level,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import psg_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_data_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_p1_ff, out_p2_ff;
   logic [4:0]  out_saw_ff;
   logic [6:0]  out_mix_ff;

   logic        swap_ff;
   logic        retire;
   logic        req_take;
   ctrl_type    ctrl;
   phase_type   phase_next;
   logic [3:0]  p1_lvl, p2_lvl;
   logic [4:0]  saw_lvl;
   logic [6:0]  mix_lvl;

   // Retire the held item: writes always go, ticks need room in the
   // result register (empty, or draining this cycle).
   assign retire    = in_valid_ff && (!in_mode_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !retire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      if (retire && in_mode_ff) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   psg_regfile u_regfile (
      .clock           (clock),
      .reset           (reset),
      .wr_en           (retire && !in_mode_ff),
      .wr_addr         (in_addr_ff),
      .wr_data         (in_data_ff),
      .swap_addr_lines (swap_ff),
      .ctrl            (ctrl)
   );

   psg_timers u_timers (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (retire && in_mode_ff),
      .ctrl       (ctrl),
      .phase_next (phase_next)
   );

   // Levels come from the post-tick phase state.
   psg_levels u_levels (
      .ctrl            (ctrl),
      .phase           (phase_next),
      .pulse_one_level (p1_lvl),
      .pulse_two_level (p2_lvl),
      .saw_level       (saw_lvl),
      .mix_level       (mix_lvl)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            swap_ff <= csr_data;
         end
      end
   end

   // payload: capture request, hold result until transferred
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_mode;
         in_addr_ff <= req_addr;
         in_data_ff <= req_data;
      end
      if (retire && in_mode_ff) begin
         out_p1_ff  <= p1_lvl;
         out_p2_ff  <= p2_lvl;
         out_saw_ff <= saw_lvl;
         out_mix_ff <= mix_lvl;
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = out_valid_ff;
   assign rsp_pulse_one_level = out_p1_ff;
   assign rsp_pulse_two_level = out_p2_ff;
   assign rsp_saw_level       = out_saw_ff;
   assign rsp_mix_level       = out_mix_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pulse_saw_sound_generator
// Drives bus writes and clock ticks with random gaps and result stalls. A
// scoreboard keeps its own copy of the channel registers and timers, works
// out the sample set of every accepted tick, and compares each accepted
// result with the oldest expected sample. The address-swap bit is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import psg_pkg::*;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef struct packed {
      logic [3:0] pulse_one;
      logic [3:0] pulse_two;
      logic [4:0] saw;
      logic [6:0] mix;
   } sample_type;

   class psg_sample_board;
      bit [3:0]   volume      [NUM_PULSE];
      bit [2:0]   duty        [NUM_PULSE];
      bit         duty_bypass [NUM_PULSE];
      bit         chan_on     [NUM_PULSE];
      bit [11:0]  period      [NUM_PULSE];
      bit [11:0]  count       [NUM_PULSE];
      bit [3:0]   step        [NUM_PULSE];
      bit [5:0]   saw_rate;
      bit [11:0]  saw_period;
      bit [11:0]  saw_count;
      bit [3:0]   saw_phase;
      bit [7:0]   saw_accum;
      bit         saw_on;
      bit         halted;
      bit         shift4;
      bit         shift8;
      bit         swap_lines;
      sample_type expected_q[$];
      int         mismatches;
      int         samples_checked;

      task report_mismatch(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         mismatches++;
      endtask

      function bit [11:0] reload(bit [11:0] p);
         if (shift8) return p >> 8;
         if (shift4) return p >> 4;
         return p;
      endfunction

      function bit [3:0] pulse_level(int ch);
         if (!chan_on[ch]) return 4'd0;
         if (duty_bypass[ch]) return volume[ch];
         return ((4'd15 - step[ch]) <= {1'b0, duty[ch]}) ? volume[ch] : 4'd0;
      endfunction

      function void apply_write(bit [15:0] addr, bit [7:0] data);
         bit [15:0] a;
         int ch;
         a = swap_lines ? {addr[15:2], addr[0], addr[1]} : addr;
         if (a == ADDR_GLOBAL_CTRL) begin
            halted = data[0];
            shift4 = data[1];
            shift8 = data[2];
         end else if (a == ADDR_SAW_RATE) begin
            saw_rate = data[5:0];
         end else if (a == ADDR_SAW_PER_LO) begin
            saw_period[7:0] = data;
         end else if (a == ADDR_SAW_PER_HI) begin
            saw_period[11:8] = data[3:0];
            saw_on = data[7];
         end else if (a[15:12] == PAGE_PULSE_ONE || a[15:12] == PAGE_PULSE_TWO) begin
            ch = (a[15:12] == PAGE_PULSE_ONE) ? 0 : 1;
            case (a[11:0])
               OFS_PULSE_CTRL: begin
                  volume[ch] = data[3:0];
                  duty[ch] = data[6:4];
                  duty_bypass[ch] = data[7];
               end
               OFS_PULSE_PER_LO: period[ch][7:0] = data;
               OFS_PULSE_PER_HI: begin
                  period[ch][11:8] = data[3:0];
                  chan_on[ch] = data[7];
               end
               default: ;
            endcase
         end
      endfunction

      function void run_timers();
         for (int ch = 0; ch < NUM_PULSE; ch++) begin
            if (count[ch] == 0) begin
               count[ch] = reload(period[ch]);
               step[ch] = step[ch] + 4'd1;
            end else begin
               count[ch] = count[ch] - 12'd1;
            end
         end
         if (saw_count == 0) begin
            saw_count = reload(saw_period);
            saw_phase = saw_phase + 4'd1;
            if (!saw_phase[0]) saw_accum = saw_accum + {2'b00, saw_rate};
            if (saw_phase >= SAW_PHASE_WRAP) begin
               saw_phase = 4'd0;
               saw_accum = 8'd0;
            end
         end else begin
            saw_count = saw_count - 12'd1;
         end
      endfunction

      // Take one accepted request; a tick queues the sample set it produces.
      function void note_item(logic mode, logic [15:0] addr, logic [7:0] data);
         sample_type s;
         if (mode == MODE_WRITE) begin
            apply_write(addr, data);
         end else begin
            if (!halted) run_timers();
            s.pulse_one = pulse_level(0);
            s.pulse_two = pulse_level(1);
            s.saw = saw_on ? saw_accum[7:3] : 5'd0;
            s.mix = {2'b00, s.pulse_one, 1'b0} + {2'b00, s.pulse_two, 1'b0}
                  + {2'b00, s.saw};
            expected_q.insert(expected_q.size(), s);
         end
      endfunction

      task check_sample(logic [3:0] p1, logic [3:0] p2, logic [4:0] sw, logic [6:0] mx);
         sample_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("sample with none expected: %0d %0d %0d %0d",
                                      p1, p2, sw, mx));
         end else begin
            want = expected_q.pop_front();
            samples_checked++;
            if (p1 !== want.pulse_one)
               report_mismatch($sformatf("pulse_one_level %0d, want %0d", p1, want.pulse_one));
            if (p2 !== want.pulse_two)
               report_mismatch($sformatf("pulse_two_level %0d, want %0d", p2, want.pulse_two));
            if (sw !== want.saw)
               report_mismatch($sformatf("saw_level %0d, want %0d", sw, want.saw));
            if (mx !== want.mix)
               report_mismatch($sformatf("mix_level %0d, want %0d", mx, want.mix));
         end
      endtask
   endclass

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 86;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode  = 1'b0;
   logic [15:0] req_addr  = 16'h0000;
   logic [7:0]  req_data  = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_pulse_one_level;
   logic [3:0]  rsp_pulse_two_level;
   logic [4:0]  rsp_saw_level;
   logic [6:0]  rsp_mix_level;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data  = 1'b0;

   psg_sample_board board = new;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int stuck_cycles  = 0;
   int items_sent    = 0;
   int csr_writes    = 0;

   pulse_saw_sound_generator DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_addr            (req_addr),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pulse_one_level (rsp_pulse_one_level),
      .rsp_pulse_two_level (rsp_pulse_two_level),
      .rsp_saw_level       (rsp_saw_level),
      .rsp_mix_level       (rsp_mix_level),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always #4 clock = ~clock;

   // Receiver side: draw a fresh stall decision every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Check every result transfer against the oldest expected sample.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_sample(rsp_pulse_one_level, rsp_pulse_two_level,
                            rsp_saw_level, rsp_mix_level);
   end

   // Watchdog: count cycles in which no channel moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d samples still expected",
                     board.expected_q.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Present one request, with an optional idle gap first; return once it
   // has transferred and the scoreboard has seen it.
   task automatic send_item(input logic mode, input logic [15:0] addr,
                            input logic [7:0] data);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_addr  <= addr;
      req_data  <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(mode, addr, data);
      items_sent++;
   endtask

   task automatic tick();
      send_item(MODE_TICK, 16'($urandom), 8'($urandom));
   endtask

   // Drop valid, wait for all samples, then let trailing writes drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_swap(input logic value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.swap_lines = value;
      csr_writes++;
   endtask

   // Short periods dominate so the steps and the saw move often; now and
   // then a full 12-bit value goes in.
   function automatic logic [7:0] period_low_byte();
      return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
   endfunction

   function automatic logic [7:0] period_high_byte();
      logic [7:0] d;
      d = 8'($urandom);
      d[7] = ($urandom_range(4) != 0);
      if ($urandom_range(5) != 0) d[3:0] = 4'h0;
      return d;
   endfunction

   task automatic send_random_item();
      int pick;
      logic [7:0] d;
      pick = $urandom_range(99);
      if (pick < 62) begin
         tick();
      end else if (pick < 92) begin
         case ($urandom_range(9))
            0: send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_CTRL}, 8'($urandom));
            1: send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_CTRL}, 8'($urandom));
            2: send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_PER_LO}, period_low_byte());
            3: send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_PER_LO}, period_low_byte());
            4: send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_PER_HI}, period_high_byte());
            5: send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_PER_HI}, period_high_byte());
            6: begin
               // Halt only now and then so the timers keep running.
               d = 8'($urandom);
               d[0] = ($urandom_range(5) == 0);
               send_item(MODE_WRITE, ADDR_GLOBAL_CTRL, d);
            end
            7: send_item(MODE_WRITE, ADDR_SAW_RATE, 8'($urandom));
            8: send_item(MODE_WRITE, ADDR_SAW_PER_LO, period_low_byte());
            default: send_item(MODE_WRITE, ADDR_SAW_PER_HI, period_high_byte());
         endcase
      end else begin
         // Noise: random addresses and near misses on the register pages.
         case ($urandom_range(2))
            0: send_item(MODE_WRITE, 16'($urandom), 8'($urandom));
            1: send_item(MODE_WRITE, {4'($urandom_range(9, 11)), 12'($urandom_range(3, 4095))},
                         8'($urandom));
            default: send_item(MODE_WRITE, {4'($urandom), 12'($urandom_range(3))},
                               8'($urandom));
         endcase
      end
   endtask

   task automatic run_directed();
      // Reset state: everything silent.
      tick();
      // Pulse one: full volume, duty ignored, zero period steps every tick.
      send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_CTRL}, 8'hFF);
      send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_PER_HI}, 8'h80);
      tick();
      // Pulse two: duty gating with period one.
      send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_CTRL}, 8'h3F);
      send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_PER_LO}, 8'h01);
      send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_PER_HI}, 8'h80);
      tick();
      tick();
      // Saw at the top rate, zero period.
      send_item(MODE_WRITE, ADDR_SAW_RATE, 8'hFF);
      send_item(MODE_WRITE, ADDR_SAW_PER_LO, 8'h00);
      send_item(MODE_WRITE, ADDR_SAW_PER_HI, 8'h80);
      tick();
      tick();
      // Unmatched addresses must leave every register alone.
      send_item(MODE_WRITE, 16'h9004, 8'hFF);
      send_item(MODE_WRITE, 16'h0000, 8'h00);
      send_item(MODE_WRITE, 16'hFFFF, 8'hFF);
      tick();
      // Both shifts set: shift by eight wins; period at its maximum.
      send_item(MODE_WRITE, ADDR_GLOBAL_CTRL, 8'h06);
      send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_PER_LO}, 8'hFF);
      send_item(MODE_WRITE, {PAGE_PULSE_ONE, OFS_PULSE_PER_HI}, 8'h8F);
      tick();
      // Halt freezes the timers but ticks still report.
      send_item(MODE_WRITE, ADDR_GLOBAL_CTRL, 8'h01);
      tick();
      tick();
      send_item(MODE_WRITE, ADDR_GLOBAL_CTRL, 8'h00);
      tick();
   endtask

   task automatic run_swapped();
      // With the swap on, offsets one and two trade places.
      send_item(MODE_WRITE, ADDR_SAW_PER_LO, 8'h05);
      tick();
      send_item(MODE_WRITE, ADDR_SAW_PER_HI, 8'h80);
      send_item(MODE_WRITE, {PAGE_PULSE_TWO, OFS_PULSE_PER_LO}, 8'h82);
      tick();
      tick();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset value of the swap bit.
      run_directed();
      write_swap(1'b1);
      run_swapped();

      // Random phases: walk the idle patterns under both swap settings.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_swap(phase >= RANDOM_PHASES / 2);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         repeat (PHASE_ITEMS) send_random_item();
      end

      settle();
      $display("sent %0d requests, checked %0d samples, %0d swap-bit writes",
               items_sent, board.samples_checked, csr_writes);
      $display("phases covered no idling, sender gaps, result stalls and both");
      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
